// ===== rtl/paged_memory_manager_assert.svh =====
// assertion macros shared by the paged memory manager rtl
`ifndef PAGED_MEMORY_MANAGER_ASSERT_SVH
`define PAGED_MEMORY_MANAGER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define PMM_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define PMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pmm_pkg.sv =====
// constants and types of the paged memory manager
package pmm_pkg;

  localparam int unsigned OffsetBits  = 10;
  localparam int unsigned AddressBits = 20;
  localparam int unsigned PhysPages   = 64;
  localparam int unsigned MaxProcs    = 16;

  localparam int unsigned VpBits      = AddressBits - OffsetBits;
  localparam int unsigned FrameBits   = $clog2(PhysPages);
  localparam int unsigned ProcBits    = $clog2(MaxProcs);
  localparam int unsigned MapAddrBits = ProcBits + VpBits;
  localparam int unsigned RamAddrBits = FrameBits + OffsetBits;
  localparam int unsigned LinkBits    = FrameBits + 1;
  localparam int unsigned PagesBits   = 12;
  localparam int unsigned BpBits      = AddressBits + 1;
  localparam int unsigned IdxBits     = 17;

  localparam logic [LinkBits-1:0] LinkEnd = LinkBits'(PhysPages);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_e;

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_COUNT   = 16'h0004,
    S_CHECK   = 16'h0008,
    S_TAKE    = 16'h0010,
    S_LINKEND = 16'h0020,
    S_FRD     = 16'h0040,
    S_FCHK    = 16'h0080,
    S_WREL    = 16'h0100,
    S_WNXT    = 16'h0200,
    S_URD     = 16'h0400,
    S_UCHK    = 16'h0800,
    S_RRD     = 16'h1000,
    S_RCHK    = 16'h2000,
    S_RWAIT   = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  // request to the shared index unit
  typedef struct packed {
    logic [IdxBits-1:0] a;
    logic [IdxBits-1:0] lim;
  } alu_req_t;

  // result of the shared index unit
  typedef struct packed {
    logic [IdxBits-1:0] inc;
    logic               hit;
  } alu_rsp_t;

endpackage

// ===== rtl/pmm_if.sv =====
// valid/ready channel interfaces of the paged memory manager
interface pmm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  process_id;
  logic [20:0] request_size;
  logic [19:0] virt_address;
  logic [7:0]  write_data;

  modport source (output valid, kind, process_id, request_size, virt_address, write_data,
                  input ready);
  modport sink (input valid, kind, process_id, request_size, virt_address, write_data,
                output ready);
endinterface

interface pmm_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [19:0] region_address;
  logic [7:0]  read_data;

  modport source (output valid, status, region_address, read_data, input ready);
  modport sink (input valid, status, region_address, read_data, output ready);
endinterface

// ===== rtl/pmm_ram.sv =====
// generic single write port ram with registered read
module pmm_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [DataWidth-1:0]       wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [DataWidth-1:0]       rdata_o
);

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/pmm_alu.sv =====
// shared index unit: increment and end compare for the sequencer counters
module pmm_alu import pmm_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  assign rsp_o.inc = req_i.a + IdxBits'(1);
  assign rsp_o.hit = (req_i.a == req_i.lim);

endmodule

// ===== rtl/paged_memory_manager.sv =====
// Paged memory manager top level: sequencer, page tables and byte ram.
// Requests come in on req_i (valid/ready), one result per request leaves on
// rsp_o (valid/ready). A request is taken only while the block is idle; the
// result is held in an output register until the receiver takes it, and the
// block stays busy until then, so a stalled receiver stalls new requests.
// The sequencer steps through the page entries with the shared index unit:
//   allocate: count the free pages, check for room, then take and chain them
//   free: release each page of the chain, then unmap the mapped pages; an
//   unmapped address fails
//   read or write: read the map entry, then the byte ram; a bad process id,
//   or a zero size on allocate, goes straight to the result
// After reset the block sweeps the map table and byte ram to zero, one entry
// each per cycle, with ready low until the sweep is done.
// Pages are handed out lowest first and linked into a chain per allocation.
module paged_memory_manager import pmm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pmm_req_if.sink   req_i,
  pmm_rsp_if.source rsp_o
);

  `include "paged_memory_manager_assert.svh"

  state_e state_q, state_d;

  logic [1:0]             kind_q;
  logic [ProcBits-1:0]    proc_q;
  logic [PagesBits-1:0]   pages_q;
  logic [AddressBits-1:0] vaddr_q;
  logic [7:0]             wdata_q;
  logic [LinkBits-1:0]    free_cnt_q;
  logic [PagesBits-1:0]   taken_q;
  logic [LinkBits-1:0]    prev_q;
  logic [LinkBits-1:0]    cur_f_q;
  logic [LinkBits-1:0]    walk_cnt_q;
  logic [VpBits:0]        vp_q;
  logic [IdxBits-1:0]     idx_q;
  logic [PhysPages-1:0]   busy_q;
  logic [BpBits-1:0]      bp_q [MaxProcs];
  logic                   status_q;
  logic [AddressBits-1:0] region_q;
  logic [7:0]             rdata_q;

  // memory ports
  logic                   map_we;
  logic [MapAddrBits-1:0] map_waddr, map_raddr;
  logic [LinkBits-1:0]    map_wdata, map_rdata;
  logic                   link_we;
  logic [FrameBits-1:0]   link_waddr, link_raddr;
  logic [LinkBits-1:0]    link_wdata, link_rdata;
  logic                   ram_we;
  logic [RamAddrBits-1:0] ram_waddr, ram_raddr;
  logic [7:0]             ram_wdata, ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic                   req_xfer, rsp_xfer;
  logic [BpBits-1:0]      bp_cur;
  logic [BpBits+1:0]      end_addr;
  logic                   no_room;
  logic                   take_now;
  logic [PagesBits:0]     pages_calc;
  logic [FrameBits-1:0]   frame;

  assign req_xfer   = req_i.valid && req_i.ready;
  assign rsp_xfer   = rsp_o.valid && rsp_o.ready;
  assign bp_cur     = bp_q[proc_q];
  assign end_addr   = {2'b00, bp_cur} + {1'b0, pages_q, OffsetBits'(0)};
  assign no_room    = (pages_q > PagesBits'(free_cnt_q)) ||
                      (end_addr > (BpBits+2)'(1) << AddressBits);
  assign take_now   = !busy_q[idx_q[FrameBits-1:0]] && (taken_q < pages_q);
  assign pages_calc = (PagesBits+1)'((22'(req_i.request_size) +
                      22'((1 << OffsetBits) - 1)) >> OffsetBits);
  assign frame      = map_rdata[FrameBits-1:0];

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = (state_q == S_DONE);
  assign rsp_o.status         = status_q;
  assign rsp_o.region_address = region_q;
  assign rsp_o.read_data      = rdata_q;

  // shared index unit
  always_comb begin
    alu_req.a   = idx_q;
    alu_req.lim = IdxBits'(PhysPages - 1);
    if (state_q == S_CLEAR) begin
      alu_req.lim = IdxBits'((1 << RamAddrBits) - 1);
    end else if (state_q == S_URD) begin
      alu_req.lim = IdxBits'(walk_cnt_q);
    end
  end

  pmm_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // memory control
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = {proc_q, vp_q[VpBits-1:0]};
    map_wdata  = {1'b0, frame};
    map_raddr  = {proc_q, vp_q[VpBits-1:0]};
    link_we    = 1'b0;
    link_waddr = prev_q[FrameBits-1:0];
    link_wdata = LinkEnd;
    link_raddr = cur_f_q[FrameBits-1:0];
    ram_we     = 1'b0;
    ram_waddr  = {frame, vaddr_q[OffsetBits-1:0]};
    ram_wdata  = wdata_q;
    ram_raddr  = {frame, vaddr_q[OffsetBits-1:0]};
    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = idx_q[MapAddrBits-1:0];
        map_wdata = '0;
        ram_we    = 1'b1;
        ram_waddr = idx_q[RamAddrBits-1:0];
        ram_wdata = '0;
      end
      S_FRD, S_RRD: begin
        map_raddr = {proc_q, vaddr_q[AddressBits-1:OffsetBits]};
      end
      S_TAKE: begin
        map_we     = take_now;
        map_waddr  = {proc_q, VpBits'(vp_q + (VpBits+1)'(taken_q))};
        map_wdata  = {1'b1, idx_q[FrameBits-1:0]};
        link_we    = take_now && (prev_q != LinkEnd);
        link_wdata = {1'b0, idx_q[FrameBits-1:0]};
      end
      S_LINKEND: begin
        link_we = (prev_q != LinkEnd);
      end
      S_UCHK: begin
        map_we = map_rdata[LinkBits-1];
      end
      S_RCHK: begin
        ram_we = map_rdata[LinkBits-1] && (kind_q == KIND_WRITE);
      end
      default: ;
    endcase
  end

  pmm_ram #(.DataWidth(LinkBits), .Depth(1 << MapAddrBits)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  pmm_ram #(.DataWidth(LinkBits), .Depth(PhysPages)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(link_raddr), .rdata_o(link_rdata)
  );

  pmm_ram #(.DataWidth(8), .Depth(1 << RamAddrBits)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:   if (alu_rsp.hit) state_d = S_IDLE;
      S_IDLE: begin
        if (req_xfer) begin
          if (req_i.process_id == 5'd0 || req_i.process_id > 5'(MaxProcs)) begin
            state_d = S_DONE;
          end else begin
            unique case (kind_e'(req_i.kind))
              KIND_ALLOC: state_d = (req_i.request_size == '0) ? S_DONE : S_COUNT;
              KIND_FREE:  state_d = S_FRD;
              KIND_READ,
              KIND_WRITE: state_d = S_RRD;
              default:    state_d = S_DONE;
            endcase
          end
        end
      end
      S_COUNT:   if (alu_rsp.hit) state_d = S_CHECK;
      S_CHECK:   state_d = no_room ? S_DONE : S_TAKE;
      S_TAKE:    if (alu_rsp.hit) state_d = S_LINKEND;
      S_LINKEND: state_d = S_DONE;
      S_FRD:     state_d = S_FCHK;
      S_FCHK:    state_d = map_rdata[LinkBits-1] ? S_WREL : S_DONE;
      S_WREL:    state_d = S_WNXT;
      S_WNXT: begin
        if (link_rdata[LinkBits-1] || walk_cnt_q[LinkBits-1]) state_d = S_URD;
        else state_d = S_WREL;
      end
      S_URD:     state_d = (alu_rsp.hit || vp_q[VpBits]) ? S_DONE : S_UCHK;
      S_UCHK:    state_d = map_rdata[LinkBits-1] ? S_URD : S_DONE;
      S_RRD:     state_d = S_RCHK;
      S_RCHK: begin
        if (map_rdata[LinkBits-1] && (kind_q == KIND_READ)) state_d = S_RWAIT;
        else state_d = S_DONE;
      end
      S_RWAIT:   state_d = S_DONE;
      S_DONE:    if (rsp_xfer) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      busy_q     <= '0;
      for (int i = 0; i < MaxProcs; i++) begin
        bp_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_CLEAR: idx_q <= alu_rsp.inc;
        S_IDLE:  idx_q <= '0;
        S_COUNT: idx_q <= alu_rsp.hit ? '0 : alu_rsp.inc;
        S_TAKE: begin
          idx_q <= alu_rsp.inc;
          if (take_now) begin
            busy_q[idx_q[FrameBits-1:0]] <= 1'b1;
          end
        end
        S_LINKEND: bp_q[proc_q] <= BpBits'(end_addr);
        S_WREL:  busy_q[cur_f_q[FrameBits-1:0]] <= 1'b0;
        S_WNXT:  idx_q <= '0;
        S_UCHK:  idx_q <= alu_rsp.inc;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          kind_q     <= req_i.kind;
          proc_q     <= ProcBits'(req_i.process_id - 5'd1);
          pages_q    <= PagesBits'(pages_calc);
          vaddr_q    <= req_i.virt_address;
          wdata_q    <= req_i.write_data;
          free_cnt_q <= '0;
          status_q   <= 1'b1;
          region_q   <= '0;
          rdata_q    <= '0;
        end
      end
      S_COUNT: begin
        if (!busy_q[idx_q[FrameBits-1:0]]) begin
          free_cnt_q <= free_cnt_q + LinkBits'(1);
        end
      end
      S_CHECK: begin
        taken_q <= '0;
        prev_q  <= LinkEnd;
        vp_q    <= {1'b0, bp_cur[AddressBits-1:OffsetBits]};
      end
      S_TAKE: begin
        if (take_now) begin
          taken_q <= taken_q + PagesBits'(1);
          prev_q  <= {1'b0, idx_q[FrameBits-1:0]};
        end
      end
      S_LINKEND: begin
        status_q <= 1'b0;
        region_q <= bp_cur[AddressBits-1:0];
      end
      S_FCHK: begin
        cur_f_q    <= {1'b0, frame};
        walk_cnt_q <= '0;
      end
      S_WREL: walk_cnt_q <= walk_cnt_q + LinkBits'(1);
      S_WNXT: begin
        cur_f_q <= link_rdata;
        vp_q    <= {1'b0, vaddr_q[AddressBits-1:OffsetBits]};
      end
      S_URD: begin
        if (alu_rsp.hit || vp_q[VpBits]) status_q <= 1'b0;
      end
      S_UCHK: begin
        if (map_rdata[LinkBits-1]) vp_q <= vp_q + (VpBits+1)'(1);
        else status_q <= 1'b0;
      end
      S_RCHK: begin
        if (map_rdata[LinkBits-1] && (kind_q == KIND_WRITE)) status_q <= 1'b0;
      end
      S_RWAIT: begin
        status_q <= 1'b0;
        rdata_q  <= ram_rdata;
      end
      default: ;
    endcase
  end

  // checks
  `PMM_ASSERT_NOW(a_ready_excl_valid, !(req_i.ready && rsp_o.valid), "ready while result held")
  `PMM_ASSERT_NEXT(a_busy_after_xfer, req_xfer, !req_i.ready, "ready right after a transfer")
  `PMM_ASSERT_NOW(a_walk_bound, !(state_q == S_WREL || state_q == S_WNXT) || walk_cnt_q <= LinkBits'(PhysPages), "chain walk ran past the page count")
  `PMM_ASSERT_NOW(a_taken_bound, state_q != S_TAKE || taken_q <= pages_q, "took more pages than asked")

endmodule
